/* design/signed_sum_divisibility_check_top_assert.svh */
// Assertion macros for the signed sum divisibility check.
// Used by the port-level checker; needs clk and arst_n in scope.
`ifndef SIGNED_SUM_DIVISIBILITY_CHECK_TOP_ASSERT_SVH
`define SIGNED_SUM_DIVISIBILITY_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define SSDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define SSDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* design/ssdc_pkg.sv */
// Shared constants and types for the signed sum divisibility check.
// No dependencies.
`default_nettype none

package ssdc_pkg;

	localparam int MAX_MODULUS = 128;
	// width that holds k itself (1..MAX_MODULUS)
	localparam int KW = $clog2(MAX_MODULUS + 1);
	// width of a residue (0..MAX_MODULUS-1)
	localparam int DW = $clog2(MAX_MODULUS);
	localparam int VW = 16;
	// magnitude width: one bit wider than a 16-bit value
	localparam int MW = VW + 1;
	localparam int CW = $clog2(MW);
	localparam int QDEPTH = 2;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic [DW-1:0] amt;
		logic          last;
	} qent_t;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

endpackage

`default_nettype wire

/* design/signed_sum_divisibility_check_top.sv */
// The front takes one item at a time and accepts no new item until its remainder is pushed to the queue.
// Its reduction is the bit-serial |value| mod k loop; the queue then feeds the back end.
// The back end updates the residue set at one item per cycle unless a last item waits for the result register.
// Reset (arst_n low, asynchronous): modulus k = 1, residue set {0}, queue and result empty.
// The configuration port never stalls; a zero modulus acts as 1, above 128 as 128.
`default_nettype none

module signed_sum_divisibility_check_top import ssdc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [7:0]    cfg_data,   // [7:0] modulus
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [VW-1:0] s_tdata,    // [15:0] value
	input  wire logic          s_tlast,    // last_value
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata     // [0] divisible, [7:1] zero
);

	logic [KW-1:0] k_q;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_valid;
	qent_t         q_wdata;
	qent_t         q_rdata;

	assign cfg_ready = 1'b1;

	// effective modulus kept ready for both ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KW'(1);
		end else if (cfg_valid) begin
			priority if (cfg_data == 8'd0) begin
				k_q <= KW'(1);
			end else if (int'(cfg_data) > MAX_MODULUS) begin
				k_q <= KW'(MAX_MODULUS);
			end else begin
				k_q <= KW'(cfg_data);
			end
		end
	end

	ssdc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.k        (k_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.q_full   (q_full)
	);

	ssdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	ssdc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.k        (k_q),
		.q_valid  (q_valid),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

/* design/ssdc_front.sv */
// Front end: takes an item, forms |value| and reduces it modulo k one bit a cycle.
// Depends on ssdc_pkg.
`default_nettype none

module ssdc_front import ssdc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [KW-1:0] k,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [VW-1:0] s_tdata,   // [15:0] value
	input  wire logic          s_tlast,   // last_value
	output logic               q_push,
	output qent_t              q_wdata,
	input  wire logic          q_full
);

	fstate_t       state_q;
	logic [MW-1:0] mag_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          last_q;
	logic [MW-1:0] mag_in;
	logic [DW:0]   trial;
	logic [DW:0]   k_ext;
	logic [DW-1:0] rem_next;

	assign s_tready = (state_q == F_IDLE);
	assign q_push   = (state_q == F_PUSH) && !q_full;
	assign q_wdata  = '{amt: rem_q, last: last_q};

	assign mag_in = s_tdata[VW-1] ? (~{1'b1, s_tdata} + MW'(1)) : {1'b0, s_tdata};

	// restoring remainder step: bring in the next magnitude bit, subtract k if it fits
	assign k_ext = (DW+1)'(k);
	assign trial = {rem_q, mag_q[MW-1]};
	always_comb begin
		if (trial >= k_ext) begin
			rem_next = DW'(trial - k_ext);
		end else begin
			rem_next = DW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MW - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_tvalid) begin
			mag_q  <= mag_in;
			rem_q  <= '0;
			last_q <= s_tlast;
		end else if (state_q == F_DIV) begin
			mag_q <= {mag_q[MW-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

`default_nettype wire

/* design/ssdc_queue.sv */
// Short queue of reduced distances between front and back ends.
// Depends on ssdc_pkg.
`default_nettype none

module ssdc_queue import ssdc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t wdata,
	output logic       full,
	input  wire logic  pop,
	output qent_t      rdata,
	output logic       valid
);

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* design/ssdc_back.sv */
// Back end: residue set update by rotate-or within k, and the result register.
// Depends on ssdc_pkg.
`default_nettype none

module ssdc_back import ssdc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [KW-1:0] k,
	input  wire logic          q_valid,
	input  wire qent_t         q_rdata,
	output logic               q_pop,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata    // [0] divisible
);

	localparam logic [MAX_MODULUS-1:0] ZERO_ONLY = MAX_MODULUS'(1);

	logic [MAX_MODULUS-1:0] set_q;
	logic [MAX_MODULUS-1:0] mask;
	logic [MAX_MODULUS-1:0] cur;
	logic [MAX_MODULUS-1:0] nxt;
	logic [KW-1:0]          fwd;
	logic [KW-1:0]          bwd;
	logic                   out_q;
	logic                   m_tvalid_q;
	logic                   out_free;

	// rotate the k-bit ring s forward by r (r < k)
	function automatic logic [MAX_MODULUS-1:0] ring_rot(input logic [MAX_MODULUS-1:0] s,
			input logic [KW-1:0] r, input logic [KW-1:0] kk);
		logic [KW-1:0] back_amt;
		back_amt = kk - r;
		return (s << r) | (s >> back_amt);
	endfunction

	// bits at or above k take no part and leave cleared
	assign mask = ~({MAX_MODULUS{1'b1}} << k);
	assign cur  = set_q & mask;
	assign fwd  = KW'(q_rdata.amt);
	assign bwd  = (q_rdata.amt == '0) ? '0 : (k - fwd);
	assign nxt  = (ring_rot(cur, fwd, k) | ring_rot(cur, bwd, k)) & mask;

	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = q_valid && (!q_rdata.last || out_free);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q      <= ZERO_ONLY;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				set_q <= q_rdata.last ? ZERO_ONLY : nxt;
			end
			if (q_pop && q_rdata.last) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_rdata.last) begin
			out_q <= nxt[0];
		end
	end

endmodule

`default_nettype wire

/* design/ssdc_checker.sv */
// Port-level checker for the signed sum divisibility check, bound to the top level.
// Depends on signed_sum_divisibility_check_top_assert.svh.
`default_nettype none
`include "signed_sum_divisibility_check_top_assert.svh"

module ssdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata
);

	`SSDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`SSDC_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")
	`SSDC_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took a second item while reducing")
	`SSDC_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "register write stalled")

endmodule

bind signed_sum_divisibility_check_top ssdc_checker u_chk (.*);

`default_nettype wire
